/* hdl/bba_pkg.sv */
// Shared constants, codes and types of the block bitmap allocator.
package bba_pkg;

   localparam int unsigned MAX_BLOCKS = 1024;
   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
   localparam int unsigned CNT_W      = IDX_W + 1;
   localparam int unsigned BIT_W      = $clog2(WORD_BITS);
   localparam int unsigned WADDR_W    = $clog2(MAP_WORDS);
   localparam int unsigned STAT_W     = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_NOT_ALLOC = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FREE,
      S_DONE
   } fsm_state_type;

   typedef struct packed {
      logic                 found;
      logic                 last;
      logic [BIT_W-1:0]     bit_pos;
      logic [WORD_BITS-1:0] new_word;
   } scan_res_type;

   typedef struct packed {
      logic                 en;
      logic [WADDR_W-1:0]   addr;
      logic [WORD_BITS-1:0] data;
   } mem_wr_type;

endpackage

/* hdl/bba_req_if.sv */
// Request channel: opcode and block index with valid/ready.
interface bba_req_if import bba_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             opcode;
   logic [IDX_W-1:0] block_index;

   modport source (output valid, output opcode, output block_index, input ready);
   modport sink   (input valid, input opcode, input block_index, output ready);
endinterface

/* hdl/bba_rsp_if.sv */
// Response channel: status, allocated index and free count with valid/ready.
interface bba_rsp_if import bba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [IDX_W-1:0]  result_index;
   logic [CNT_W-1:0]  free_count;

   modport source (output valid, output status, output result_index, output free_count,
                   input ready);
   modport sink   (input valid, input status, input result_index, input free_count,
                   output ready);
endinterface

/* hdl/bba_map_mem.sv */
// Used-block bitmap store: one write and one registered read a cycle, per-word valid bits.
module bba_map_mem import bba_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [WADDR_W-1:0]   rd_addr,
   output logic [WORD_BITS-1:0] rd_word,
   input  mem_wr_type           wr
);

   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // a word never written reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_word = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* hdl/bba_scan_unit.sv */
// Word scanner: masks blocks beyond the total and finds the lowest free bit.
module bba_scan_unit import bba_pkg::*; (
   input  logic [WORD_BITS-1:0] map_word,
   input  logic [WADDR_W-1:0]   word_addr,
   input  logic [CNT_W-1:0]     total,
   output scan_res_type         res
);

   logic [CNT_W-1:0]     base;
   logic [CNT_W-1:0]     rem;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] free_bits;
   logic [BIT_W-1:0]     pos;

   assign base = CNT_W'({word_addr, {BIT_W{1'b0}}});
   assign rem  = (total > base) ? (total - base) : '0;
   assign mask = (rem >= CNT_W'(WORD_BITS)) ? '1
                                            : ~({WORD_BITS{1'b1}} << rem[BIT_W-1:0]);
   assign free_bits = ~map_word & mask;

   always_comb begin
      pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            pos = BIT_W'(b);
         end
      end
   end

   assign res.found    = |free_bits;
   assign res.last     = (rem <= CNT_W'(WORD_BITS));
   assign res.bit_pos  = pos;
   assign res.new_word = map_word | (WORD_BITS'(1) << pos);

endmodule

/* hdl/block_bitmap_allocator.sv */
// Top level of the first-fit block bitmap allocator.
//
//   port       dir   word                                   handshake
//   req_chan   in    opcode, block_index                    valid/ready
//   rsp_chan   out   status, result_index, free_count       valid/ready
//   csr_wr_*   in    total_blocks (11 bits)                 write enable, no wait
//
// Allocate: scans N bitmap words (1..32), then responds; the map
// store gives one word a cycle to the scanner, reads running one word ahead.
// Free: read, test and write back, respond; out of range: respond only, with no map write.
// Reset clears the map at once through per-word valid bits; no clearing pass.
// A new word is taken while the previous response still waits on rsp_chan.ready;
// the block holds its own result until the response register is free.
module block_bitmap_allocator import bba_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   bba_req_if.sink          req_chan,
   bba_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   fsm_state_type state_ff, state_in;

   logic [CNT_W-1:0]   total_ff;
   logic [CNT_W-1:0]   used_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [WADDR_W-1:0] cur_ff;
   status_type         status_ff;
   logic [IDX_W-1:0]   res_idx_ff;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [IDX_W-1:0]   rsp_index_ff;
   logic [CNT_W-1:0]   rsp_free_ff;

   logic               accept;
   logic               range_bad;
   logic               slot_free;
   logic               bit_used;
   logic [WADDR_W-1:0] rd_addr;
   logic [WORD_BITS-1:0] rd_word;
   mem_wr_type         wr;
   scan_res_type       scan;
   logic [CNT_W-1:0]   free_now;

   bba_map_mem u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_word (rd_word),
      .wr      (wr)
   );

   bba_scan_unit u_scan (
      .map_word  (rd_word),
      .word_addr (cur_ff),
      .total     (total_ff),
      .res       (scan)
   );

   assign accept    = req_chan.valid && req_chan.ready;
   assign range_bad = ({1'b0, req_chan.block_index} >= total_ff);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign bit_used  = rd_word[idx_ff[BIT_W-1:0]];
   assign free_now  = (total_ff > used_ff) ? (total_ff - used_ff) : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_chan.opcode == OP_FREE) begin
                  state_in = range_bad ? S_DONE : S_FREE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan.found || scan.last) begin
               state_in = S_DONE;
            end
         end
         S_FREE: state_in = S_DONE;
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready = 1'b0;
      rd_addr        = '0;
      wr.en          = 1'b0;
      wr.addr        = cur_ff;
      wr.data        = scan.new_word;
      unique case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.opcode == OP_FREE) begin
               rd_addr = req_chan.block_index[IDX_W-1:BIT_W];
            end
         end
         S_SCAN: begin
            // fetch the next word while this one is checked
            rd_addr = cur_ff + WADDR_W'(1);
            wr.en   = scan.found;
         end
         S_FREE: begin
            wr.en   = bit_used;
            wr.addr = idx_ff[IDX_W-1:BIT_W];
            wr.data = rd_word & ~(WORD_BITS'(1) << idx_ff[BIT_W-1:0]);
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= CNT_W'(MAX_BLOCKS);
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            total_ff <= (csr_wr_data > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : csr_wr_data;
         end
         if (state_ff == S_SCAN && scan.found) begin
            used_ff <= used_ff + CNT_W'(1);
         end else if (state_ff == S_FREE && bit_used) begin
            used_ff <= used_ff - CNT_W'(1);
         end
         if (state_ff == S_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff     <= req_chan.block_index;
         cur_ff     <= '0;
         res_idx_ff <= '0;
         status_ff  <= (req_chan.opcode == OP_FREE && range_bad) ? ST_RANGE : ST_OK;
      end
      if (state_ff == S_SCAN) begin
         cur_ff <= cur_ff + WADDR_W'(1);
         if (scan.found) begin
            res_idx_ff <= {cur_ff, scan.bit_pos};
         end else if (scan.last) begin
            status_ff <= ST_NO_SPACE;
         end
      end
      if (state_ff == S_FREE && !bit_used) begin
         status_ff <= ST_NOT_ALLOC;
      end
      if (state_ff == S_DONE && slot_free) begin
         rsp_status_ff <= status_ff;
         rsp_index_ff  <= res_idx_ff;
         rsp_free_ff   <= free_now;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.result_index = rsp_index_ff;
   assign rsp_chan.free_count   = rsp_free_ff;

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(MAX_BLOCKS))
      else $error("used count above block maximum");

   a_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == S_SCAN || state_ff == S_FREE))
      else $error("bitmap written outside scan or free");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("sequencer idle right after a request word");

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && slot_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished request did not reach the response register");

endmodule

/* sim/block_bitmap_allocator_test.sv */
// Self-checking testbench for the first-fit block bitmap allocator.
`timescale 1ns / 1ps

module block_bitmap_allocator_test;
   import bba_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned IDLE_PCT    = 16;
   localparam int unsigned DRAIN_WAIT  = 40;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] result_index;
      logic [CNT_W-1:0] free_count;
   } reply_type;

   typedef struct {
      bit               is_cfg;
      logic [CNT_W-1:0] cfg_value;
      logic             opcode;
      logic [IDX_W-1:0] block_index;
      bit               typed;
      reply_type        reply;
   } script_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   bba_req_if req_chan ();
   bba_rsp_if rsp_chan ();

   block_bitmap_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predicted state of the allocator
   logic [MAX_BLOCKS-1:0] block_used;
   logic [CNT_W-1:0]      blocks_taken;
   logic [CNT_W-1:0]      total_setting;

   reply_type      replies_due[$];
   script_row_type script[$];
   int unsigned    faults = 0;
   int unsigned    cycle_count = 0;
   bit             gaps_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[block_bitmap_allocator] ERROR");
         $finish;
      end
   end

   function automatic int unsigned usable_blocks();
      return (total_setting > MAX_BLOCKS) ? MAX_BLOCKS : int'(total_setting);
   endfunction

   // Applies one word to the predicted bitmap and returns the reply it earns.
   function automatic reply_type serve_request(logic op, logic [IDX_W-1:0] idx);
      reply_type   r;
      int unsigned lim;
      int unsigned pos;
      lim = usable_blocks();
      r.status       = ST_OK;
      r.result_index = '0;
      if (op == OP_ALLOC) begin
         pos = lim;
         for (int unsigned i = 0; i < lim && pos == lim; i++)
            if (!block_used[i]) pos = i;
         if (pos < lim) begin
            block_used[pos] = 1'b1;
            blocks_taken    = blocks_taken + 1'b1;
            r.result_index  = IDX_W'(pos);
         end else begin
            r.status = ST_NO_SPACE;
         end
      end else if (idx >= lim) begin
         r.status = ST_RANGE;
      end else if (!block_used[idx]) begin
         r.status = ST_NOT_ALLOC;
      end else begin
         block_used[idx] = 1'b0;
         blocks_taken    = blocks_taken - 1'b1;
      end
      // saturates when a shrunk total leaves blocks in use above it
      r.free_count = (lim > blocks_taken) ? CNT_W'(lim - blocks_taken) : '0;
      return r;
   endfunction

   // Often a block that is in use, otherwise an index up to just past the total or anywhere.
   function automatic logic [IDX_W-1:0] pick_free_index();
      int unsigned lim;
      int unsigned roll;
      int unsigned start;
      int unsigned k;
      lim  = usable_blocks();
      roll = $urandom_range(0, 99);
      if (roll < 45 && lim > 0) begin
         start = $urandom_range(0, lim - 1);
         for (k = 0; k < lim; k++)
            if (block_used[(start + k) % lim]) return IDX_W'((start + k) % lim);
      end
      if (roll < 85)
         return IDX_W'($urandom_range(0, (lim + 3 > MAX_BLOCKS - 1) ? MAX_BLOCKS - 1 : lim + 3));
      return IDX_W'($urandom_range(0, MAX_BLOCKS - 1));
   endfunction

   function automatic void plan_word(logic op, int unsigned idx, bit typed,
                                     status_type st, int unsigned ri, int unsigned fc);
      script_row_type row;
      row.is_cfg       = 1'b0;
      row.cfg_value    = '0;
      row.opcode       = op;
      row.block_index  = IDX_W'(idx);
      row.typed        = typed;
      row.reply.status       = st;
      row.reply.result_index = IDX_W'(ri);
      row.reply.free_count   = CNT_W'(fc);
      script.push_back(row);
   endfunction

   function automatic void plan_total(int unsigned value);
      script_row_type row;
      row        = '{default: '0};
      row.is_cfg    = 1'b1;
      row.cfg_value = CNT_W'(value);
      script.push_back(row);
   endfunction

   // Called at an edge; returns at the edge where the word is taken.
   task automatic send_request(logic op, logic [IDX_W-1:0] idx, bit typed,
                               reply_type typed_reply);
      reply_type r;
      while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.opcode      <= op;
      req_chan.block_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
      r = serve_request(op, idx);
      replies_due.push_back(typed ? typed_reply : r);
   endtask

   // Drain first: nothing is in flight when the register changes.
   task automatic write_total(logic [CNT_W-1:0] value);
      req_chan.valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      total_setting = value;
   endtask

   task automatic run_phase(int unsigned total, int unsigned count, int unsigned alloc_pct);
      logic op;
      logic [IDX_W-1:0] idx;
      write_total(CNT_W'(total));
      repeat (count) begin
         op  = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
         idx = (op == OP_FREE) ? pick_free_index() : IDX_W'($urandom_range(0, MAX_BLOCKS - 1));
         send_request(op, idx, 1'b0, '0);
      end
   endtask

   // result side: random back-pressure and checking
   initial begin
      reply_type want;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (replies_due.size() == 0) begin
               $error("unexpected reply word: status %0d index %0d free %0d",
                      rsp_chan.status, rsp_chan.result_index, rsp_chan.free_count);
               faults++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
                  faults++;
               end
               if (rsp_chan.result_index !== want.result_index) begin
                  $error("result_index: expected %0d, got %0d",
                         want.result_index, rsp_chan.result_index);
                  faults++;
               end
               if (rsp_chan.free_count !== want.free_count) begin
                  $error("free_count: expected %0d, got %0d",
                         want.free_count, rsp_chan.free_count);
                  faults++;
               end
            end
         end
         rsp_chan.ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
      end
   end

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_chan.valid       = 1'b0;
      req_chan.opcode      = OP_ALLOC;
      req_chan.block_index = '0;
      gaps_on              = 1'b1;
      block_used           = '0;
      blocks_taken         = '0;
      total_setting        = CNT_W'(MAX_BLOCKS);

      // after reset: full map of 1024 blocks
      plan_word(OP_ALLOC,    0, 1, ST_OK,        0, 1023);
      plan_word(OP_ALLOC,    0, 1, ST_OK,        1, 1022);
      plan_word(OP_FREE,     0, 1, ST_OK,        0, 1023);
      plan_word(OP_FREE,     0, 1, ST_NOT_ALLOC, 0, 1023);
      plan_word(OP_ALLOC,    0, 1, ST_OK,        0, 1022);
      plan_word(OP_FREE,  1023, 1, ST_NOT_ALLOC, 0, 1022);
      plan_word(OP_FREE,     1, 1, ST_OK,        0, 1023);
      plan_word(OP_FREE,     0, 1, ST_OK,        0, 1024);
      // no blocks at all
      plan_total(0);
      plan_word(OP_ALLOC,    0, 1, ST_NO_SPACE,  0, 0);
      plan_word(OP_FREE,     0, 1, ST_RANGE,     0, 0);
      // total above the maximum clips to it
      plan_total(2047);
      plan_word(OP_ALLOC,    0, 1, ST_OK,        0, 1023);
      plan_word(OP_FREE,  1023, 1, ST_NOT_ALLOC, 0, 1023);
      plan_total(1);
      plan_word(OP_ALLOC,    0, 1, ST_NO_SPACE,  0, 0);
      plan_word(OP_FREE,     0, 1, ST_OK,        0, 1);
      plan_word(OP_ALLOC,    0, 1, ST_OK,        0, 0);
      plan_word(OP_FREE,     1, 1, ST_RANGE,     0, 0);
      plan_total(3);
      plan_word(OP_ALLOC,    0, 1, ST_OK,        1, 1);
      plan_word(OP_ALLOC,    0, 1, ST_OK,        2, 0);
      plan_word(OP_ALLOC,    0, 1, ST_NO_SPACE,  0, 0);
      // shrink below blocks in use: free count saturates, freeing above is out of range
      plan_total(1);
      plan_word(OP_FREE,     2, 1, ST_RANGE,     0, 0);
      plan_total(1024);
      plan_word(OP_FREE,     2, 1, ST_OK,        0, 1022);
      plan_word(OP_FREE,     1, 0, ST_OK,        0, 0);
      plan_word(OP_ALLOC, 1023, 0, ST_OK,        0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[n]) begin
         if (script[n].is_cfg)
            write_total(script[n].cfg_value);
         else
            send_request(script[n].opcode, script[n].block_index, script[n].typed,
                         script[n].reply);
      end

      run_phase(1024, 300, 85);
      run_phase(40,    80, 50);
      run_phase(0,     20, 50);
      gaps_on = 1'b0;
      run_phase(1500, 150, 30);
      gaps_on = 1'b1;
      run_phase(5,     60, 55);
      run_phase(1,     30, 50);
      run_phase(200,  150, 50);
      run_phase(1024, 150, 45);

      req_chan.valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (faults == 0)
         $display("[block_bitmap_allocator] OK");
      else
         $display("[block_bitmap_allocator] ERROR");
      $finish;
   end

endmodule

/* sim.f */
hdl/bba_pkg.sv
hdl/bba_req_if.sv
hdl/bba_rsp_if.sv
hdl/bba_map_mem.sv
hdl/bba_scan_unit.sv
hdl/block_bitmap_allocator.sv
sim/block_bitmap_allocator_test.sv
